// ===== hw/rtl/alfg_pkg.sv =====
// Shared constants and types for the additive lagged Fibonacci generator.
`default_nettype none
package alfg_pkg;

  localparam int MAX_LAG = 1024;
  localparam int IDX_W   = $clog2(MAX_LAG);
  localparam int R_W     = $clog2(MAX_LAG + 1);
  localparam int LAG_W   = 11;
  localparam int CMP_W   = (LAG_W > R_W) ? LAG_W : R_W;
  localparam int WORD_W  = 32;
  localparam int OUT_W   = 34;
  localparam int ADDR_W  = 4;

  localparam int DIV_STEPS = WORD_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MODULUS   = 2'd0;
  localparam reg_idx_t REG_OFFSET    = 2'd1;
  localparam reg_idx_t REG_LONG_LAG  = 2'd2;
  localparam reg_idx_t REG_SHORT_LAG = 2'd3;

  localparam logic [WORD_W-1:0] MODULUS_RST   = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] OFFSET_RST    = 32'h0000_0000;
  localparam logic [LAG_W-1:0]  LONG_LAG_RST  = 11'd17;
  localparam logic [LAG_W-1:0]  SHORT_LAG_RST = 11'd5;

  typedef enum logic [2:0] {
    ST_FAST = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } calc_st_t;

endpackage
`default_nettype wire

// ===== hw/rtl/additive_lagged_fibonacci_generator.sv =====
// Top level: lag ring memory, read-modify-write pipeline, remainder unit, APB registers.
//
//   channel  direction  beat fields                handshake
//   in       input      in_func, in_seed_word      in_valid / in_stall
//   out      output     out_random_value           out_valid / out_stall
//   apb      input      4 registers at 4*i         psel, penable, pwrite, pready
//
// One item per cycle unless in_stall holds the input; a generate result goes from
// the read stage into the output register. The ring is one memory with two read ports
// and one write port: reads issue on accept, the sum is reduced and written back in
// the next stage, with forwarding when the following item reads the entry being written.
// A seed not below the modulus, or a ring entry not below it (after the modulus
// was changed), goes through a bit-serial remainder unit.
// rst_n is synchronous and clears control state only; the ring needs seeding.
// A stall on out holds the output register and backs up into in_stall.
`default_nettype none
module additive_lagged_fibonacci_generator (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_func,
  input  wire  [alfg_pkg::WORD_W-1:0]      in_seed_word,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic signed [alfg_pkg::OUT_W-1:0] out_random_value,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [alfg_pkg::ADDR_W-1:0]      paddr,
  input  wire  [alfg_pkg::WORD_W-1:0]      pwdata,
  output logic [alfg_pkg::WORD_W-1:0]      prdata,
  output logic                             pready
);
  import alfg_pkg::*;

  // configuration registers
  logic [WORD_W-1:0] modulus_r;
  logic [WORD_W-1:0] offset_r;
  logic [LAG_W-1:0]  long_lag_r;
  logic [LAG_W-1:0]  short_lag_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  // effective lags and modulus
  logic [WORD_W:0]   m_eff;
  logic [CMP_W-1:0]  lag_ext;
  logic [CMP_W-1:0]  r_cmp;
  logic [CMP_W-1:0]  s_ext;
  logic [R_W-1:0]    r_eff;
  logic [R_W-1:0]    s_eff;

  // positions
  logic [IDX_W-1:0]  gen_pos_r;
  logic [IDX_W-1:0]  load_pos_r;
  logic [R_W-1:0]    gen_i;
  logic [R_W-1:0]    gen_inc;
  logic [R_W-1:0]    gen_j;
  logic [R_W-1:0]    load_i;
  logic [R_W-1:0]    load_inc;

  // ring memory
  logic [WORD_W-1:0] ring_mem [MAX_LAG];
  logic [WORD_W-1:0] rd_i_r;
  logic [WORD_W-1:0] rd_j_r;
  logic [IDX_W-1:0]  ra_i;
  logic [IDX_W-1:0]  ra_j;

  // compute stage
  logic              accept_in;
  logic              b_valid_r;
  logic              b_func_r;
  logic [IDX_W-1:0]  b_waddr_r;
  logic [WORD_W-1:0] b_seed_r;
  logic              fwd_i_r;
  logic              fwd_j_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic [WORD_W-1:0] op_i;
  logic [WORD_W-1:0] op_j;
  logic [WORD_W:0]   sum;
  logic [WORD_W:0]   sum_red;
  logic              fast_ok;
  logic [WORD_W-1:0] fast_val;
  logic              result_ok;
  logic [WORD_W-1:0] result;
  logic              out_free;
  logic              b_done;

  // remainder unit
  calc_st_t          st_r;
  calc_st_t          st_nxt;
  logic [WORD_W:0]   div_num_r;
  logic [WORD_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W-1:0] rem_nxt;

  // output register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_value_r;

  // ---------------- configuration ----------------
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RST;
      offset_r    <= OFFSET_RST;
      long_lag_r  <= LONG_LAG_RST;
      short_lag_r <= SHORT_LAG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODULUS:   modulus_r   <= pwdata;
        REG_OFFSET:    offset_r    <= pwdata;
        REG_LONG_LAG:  long_lag_r  <= pwdata[LAG_W-1:0];
        REG_SHORT_LAG: short_lag_r <= pwdata[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS:   prdata = modulus_r;
      REG_OFFSET:    prdata = offset_r;
      REG_LONG_LAG:  prdata = WORD_W'(long_lag_r);
      REG_SHORT_LAG: prdata = WORD_W'(short_lag_r);
      default:       prdata = '0;
    endcase
  end

  // modulus zero means 2^32
  assign m_eff = {~|modulus_r, modulus_r};

  always_comb begin
    lag_ext = CMP_W'(long_lag_r);
    if (lag_ext == '0)
      r_cmp = CMP_W'(1);
    else if (lag_ext > CMP_W'(MAX_LAG))
      r_cmp = CMP_W'(MAX_LAG);
    else
      r_cmp = lag_ext;
    r_eff = R_W'(r_cmp);
    s_ext = CMP_W'(short_lag_r);
    s_eff = (s_ext > r_cmp) ? r_eff : R_W'(s_ext);
  end

  // ---------------- positions ----------------
  always_comb begin
    gen_i    = (R_W'(gen_pos_r) >= r_eff) ? '0 : R_W'(gen_pos_r);
    gen_inc  = (gen_i + R_W'(1) == r_eff) ? '0 : gen_i + R_W'(1);
    gen_j    = (gen_i >= s_eff) ? gen_i - s_eff : gen_i + (r_eff - s_eff);
    load_i   = (R_W'(load_pos_r) >= r_eff) ? '0 : R_W'(load_pos_r);
    load_inc = (load_i + R_W'(1) == r_eff) ? '0 : load_i + R_W'(1);
    ra_i     = gen_i[IDX_W-1:0];
    ra_j     = gen_j[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_pos_r  <= '0;
      load_pos_r <= '0;
    end else if (accept_in) begin
      if (in_func == FUNC_GEN)
        gen_pos_r <= gen_inc[IDX_W-1:0];
      else
        load_pos_r <= load_inc[IDX_W-1:0];
    end
  end

  // ---------------- ring memory ----------------
  always_ff @(posedge clk) begin
    if (b_done)
      ring_mem[b_waddr_r] <= result;
    if (accept_in) begin
      rd_i_r <= ring_mem[ra_i];
      rd_j_r <= ring_mem[ra_j];
    end
  end

  // ---------------- compute stage ----------------
  assign accept_in = in_valid && !in_stall;
  assign in_stall  = b_valid_r && !b_done;

  always_ff @(posedge clk) begin
    if (!rst_n)
      b_valid_r <= 1'b0;
    else if (accept_in)
      b_valid_r <= 1'b1;
    else if (b_done)
      b_valid_r <= 1'b0;
  end

  // entry written this cycle is read again by the item entering now
  always_ff @(posedge clk) begin
    if (accept_in) begin
      b_func_r   <= in_func;
      b_seed_r   <= in_seed_word;
      b_waddr_r  <= (in_func == FUNC_GEN) ? ra_i : load_i[IDX_W-1:0];
      fwd_i_r    <= b_done && (b_waddr_r == ra_i);
      fwd_j_r    <= b_done && (b_waddr_r == ra_j);
      fwd_data_r <= result;
    end
  end

  always_comb begin
    op_i    = fwd_i_r ? fwd_data_r : rd_i_r;
    op_j    = fwd_j_r ? fwd_data_r : rd_j_r;
    sum     = {1'b0, op_i} + {1'b0, op_j};
    sum_red = (sum >= m_eff) ? sum - m_eff : sum;
    if (b_func_r == FUNC_GEN) begin
      fast_ok  = ({1'b0, op_i} < m_eff) && ({1'b0, op_j} < m_eff);
      fast_val = sum_red[WORD_W-1:0];
    end else begin
      fast_ok  = {1'b0, b_seed_r} < m_eff;
      fast_val = b_seed_r;
    end
    case (st_r)
      ST_FAST: begin
        result_ok = fast_ok;
        result    = fast_val;
      end
      ST_DONE: begin
        result_ok = 1'b1;
        result    = rem_r;
      end
      default: begin
        result_ok = 1'b0;
        result    = rem_r;
      end
    endcase
    out_free = !out_valid_r || !out_stall;
    b_done   = b_valid_r && result_ok && ((b_func_r == FUNC_LOAD) || out_free);
  end

  // ---------------- remainder unit ----------------
  always_comb begin
    rem_sh  = {rem_r, div_num_r[WORD_W]};
    rem_nxt = (rem_sh >= m_eff) ? WORD_W'(rem_sh - m_eff) : rem_sh[WORD_W-1:0];
    st_nxt  = st_r;
    case (st_r)
      ST_FAST: if (b_valid_r && !fast_ok) st_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) st_nxt = ST_DONE;
      ST_DONE: if (b_done) st_nxt = ST_FAST;
      default: st_nxt = ST_FAST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      st_r <= ST_FAST;
    else
      st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_FAST: begin
        div_num_r <= (b_func_r == FUNC_GEN) ? sum : {1'b0, b_seed_r};
        rem_r     <= '0;
        cnt_r     <= '0;
      end
      ST_DIV: begin
        div_num_r <= {div_num_r[WORD_W-1:0], 1'b0};
        rem_r     <= rem_nxt;
        cnt_r     <= cnt_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (b_done && (b_func_r == FUNC_GEN))
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (b_done && (b_func_r == FUNC_GEN))
      out_value_r <= {{(OUT_W - WORD_W){offset_r[WORD_W-1]}}, offset_r}
                     + {{(OUT_W - WORD_W){1'b0}}, result};
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

endmodule
`default_nettype wire

// ===== tb/additive_lagged_fibonacci_generator_tb.sv =====
// Self-checking testbench for the additive lagged Fibonacci generator.
`timescale 1ns / 1ps
module additive_lagged_fibonacci_generator_tb;
  import alfg_pkg::*;

  localparam int SETTLE_CYCLES = 40;   // slow remainder path plus pipeline
  localparam int STALL_LIMIT   = 2000; // cycles with no beat on either channel
  localparam int GEN_PERCENT   = 75;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic        func;
    logic [31:0] seed;
  } ring_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_func = FUNC_LOAD;
  logic [WORD_W-1:0]       in_seed_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_random_value;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [WORD_W-1:0]       pwdata = '0;
  logic [WORD_W-1:0]       prdata;
  logic                    pready;

  additive_lagged_fibonacci_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_seed_word     (in_seed_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_random_value (out_random_value),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers, ring and both positions
  logic [31:0] cfg_modulus = MODULUS_RST;
  logic [31:0] cfg_offset = OFFSET_RST;
  logic [10:0] cfg_long_lag = LONG_LAG_RST;
  logic [10:0] cfg_short_lag = SHORT_LAG_RST;
  logic [31:0] lag_entries [MAX_LAG];
  int          gen_pos = 0;
  int          load_pos = 0;

  ring_beat_t  pending_beats[$];
  logic [33:0] expected_values[$];
  ring_beat_t  next_beat;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          seeded_len = 0;
  int          mismatches = 0;
  int          n_loads = 0;
  int          n_gens = 0;
  int          n_checked = 0;
  int          n_settings = 1;
  int          quiet_cycles = 0;

  logic [31:0] directed_seeds [17] = '{
    32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
    32'hFFFF_FFFD, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002, 32'h0000_FFFF,
    32'hFFFF_0000, 32'h0000_0003, 32'h1234_5678, 32'hFFFF_FFFE, 32'hEDCB_A987,
    32'h0000_0004, 32'hFFFF_FFFC
  };

  function automatic int eff_long_lag(input logic [10:0] lag);
    if (lag == 0) return 1;
    if (lag > MAX_LAG) return MAX_LAG;
    return lag;
  endfunction

  task automatic step_lag_ring(input logic func, input logic [31:0] seed);
    logic [63:0] m;
    logic [63:0] sum;
    logic [63:0] val;
    logic [31:0] entry;
    longint      base;
    int          r;
    int          s;
    int          j;
    m = (cfg_modulus == 0) ? 64'h1_0000_0000 : 64'(cfg_modulus);
    r = eff_long_lag(cfg_long_lag);
    s = (cfg_short_lag > r) ? r : cfg_short_lag;
    if (func == FUNC_LOAD) begin
      if (load_pos >= r) load_pos = 0;
      lag_entries[load_pos] = 32'(64'(seed) % m);
      load_pos = (load_pos + 1) % r;
    end else begin
      if (gen_pos >= r) gen_pos = 0;
      j = (r + gen_pos - s) % r;
      sum = 64'(lag_entries[j]) + 64'(lag_entries[gen_pos]);
      entry = 32'(sum % m);
      lag_entries[gen_pos] = entry;
      base = $signed(cfg_offset);
      val = base + 64'(entry);
      expected_values.push_back(val[33:0]);
      gen_pos = (gen_pos + 1) % r;
    end
  endtask

  function automatic logic send_gap();
    if (idle_mode == IDLE_SEND) return $urandom_range(99) < 59;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 17;
    return 1'b0;
  endfunction

  // Input side: predict on every accepted beat, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_lag_ring(in_func, in_seed_word);
        if (in_func == FUNC_LOAD) n_loads++;
        else n_gens++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && !send_gap()) begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_func <= next_beat.func;
          in_seed_word <= next_beat.seed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each beat, then decide the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_values.size() == 0) begin
          $error("random_value: expected none, actual %0d", out_random_value);
          mismatches++;
        end else if (out_random_value !== expected_values[0]) begin
          $error("random_value: expected %0d, actual %0d",
                 $signed(expected_values[0]), out_random_value);
          mismatches++;
          void'(expected_values.pop_front());
        end else begin
          void'(expected_values.pop_front());
        end
      end
      case (idle_mode)
        IDLE_RECV: out_stall <= $urandom_range(99) < 59;
        IDLE_BOTH: out_stall <= $urandom_range(99) < 17;
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] pick_seed(input logic [31:0] mod_reg);
    logic [63:0] m;
    logic [31:0] w;
    m = (mod_reg == 0) ? 64'h1_0000_0000 : 64'(mod_reg);
    if ($urandom_range(99) < 15) w = $urandom_range(32'hFFFF_FFFE, 0);
    else w = 32'(64'($urandom()) % m);
    if (w == 32'hFFFF_FFFF) w = 32'hFFFF_FFFE;
    return w;
  endfunction

  // One register setting: write all four while idle, seed if the ring grew, then mix
  task automatic run_phase(input logic [31:0] m, input logic [31:0] off,
                           input logic [10:0] long_lag, input logic [10:0] short_lag,
                           input int n, input idle_mode_t mode);
    ring_beat_t b;
    int         r;
    wait_drained();
    apb_write(REG_MODULUS, m);
    apb_write(REG_OFFSET, off);
    apb_write(REG_LONG_LAG, 32'(long_lag));
    apb_write(REG_SHORT_LAG, 32'(short_lag));
    cfg_modulus = m;
    cfg_offset = off;
    cfg_long_lag = long_lag;
    cfg_short_lag = short_lag;
    n_settings++;
    idle_mode = mode;
    r = eff_long_lag(long_lag);
    // r consecutive loads cover every entry below r whatever the load position
    if (r > seeded_len) begin
      for (int k = 0; k < r; k++) begin
        b.func = FUNC_LOAD;
        b.seed = pick_seed(m);
        pending_beats.push_back(b);
      end
      seeded_len = r;
    end
    for (int k = 0; k < n; k++) begin
      b.func = ($urandom_range(99) < GEN_PERCENT) ? FUNC_GEN : FUNC_LOAD;
      b.seed = (b.func == FUNC_GEN) ? 32'($urandom()) : pick_seed(m);
      if (b.seed == 32'hFFFF_FFFF) b.seed = 32'h0;
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    ring_beat_t b;
    idle_mode_t mode;
    logic [31:0] rnd_mod;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: seed all 17 entries with edge values, then generate
    foreach (directed_seeds[k]) begin
      b.func = FUNC_LOAD;
      b.seed = directed_seeds[k];
      pending_beats.push_back(b);
    end
    seeded_len = 17;
    for (int k = 0; k < 8; k++) begin
      b.func = FUNC_GEN;
      b.seed = (k % 2 == 0) ? 32'hFFFF_FFFE : 32'h0;
      pending_beats.push_back(b);
    end

    // modulus one with lag one and zero short lag; old entries now above modulus
    run_phase(32'd1, 32'h8000_0000, 11'd1, 11'd0, 60, IDLE_SEND);
    // modulus 2^32, long lag zero, short lag clamped
    run_phase(32'd0, 32'h7FFF_FFFF, 11'd0, 11'd2047, 60, IDLE_RECV);
    // short lag one exercises forwarding
    run_phase(32'hFFFF_FFFF, $urandom(), 11'd2, 11'd1, 80, IDLE_BOTH);
    run_phase(32'd7, 32'hFFFF_FFFB, 11'd17, 11'd5, 80, IDLE_NONE);
    // lag lowered under both positions; short equal to long doubles the entry
    run_phase(32'd1000, 32'h0, 11'd5, 11'd5, 80, IDLE_SEND);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024, 11'd1023, 60, IDLE_BOTH);
    run_phase(32'd0, 32'h8000_0000, 11'd2047, 11'd1, 60, IDLE_RECV);
    run_phase($urandom(), $urandom(), 11'd24, 11'd10, 80, IDLE_NONE);
    for (int p = 0; p < 3; p++) begin
      mode = idle_mode_t'(p + 1);
      rnd_mod = ($urandom_range(2) == 0) ? $urandom_range(50, 2) : $urandom();
      run_phase(rnd_mod, $urandom(), 11'($urandom_range(40, 2)),
                11'($urandom_range(45, 0)), 80, mode);
    end
    wait_drained();

    $display("Ran %0d seed loads and %0d generate beats over %0d register settings.",
             n_loads, n_gens, n_settings);
    $display("Compared %0d output values, %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
